// File: design/ccw_pkg.sv
// Package with the shared constants and state codes of the canonical codeword assigner.
`default_nettype none

package ccw_pkg;

   // Width of a codeword and of the length field.
   localparam int CW_W  = 32;
   localparam int LEN_W = 6;

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_FILL = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

endpackage

`default_nettype wire

// File: design/ccw_if.sv
// Valid/ready channel interfaces for the code length beats and the codeword beats.
`default_nettype none

interface ccw_req_if;
   logic                      valid;
   logic                      ready;
   logic [ccw_pkg::LEN_W-1:0] code_length;
   logic                      first_entry;
   logic                      last_entry;

   modport source (output valid, code_length, first_entry, last_entry, input ready);
   modport sink   (input valid, code_length, first_entry, last_entry, output ready);
endinterface

interface ccw_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [ccw_pkg::CW_W-1:0] codeword;
   logic                     overfull;
   logic                     incomplete;
   logic                     last_out;

   modport source (output valid, codeword, overfull, incomplete, last_out, input ready);
   modport sink   (input valid, codeword, overfull, incomplete, last_out, output ready);
endinterface

`default_nettype wire

// File: design/ccw_slot_mem.sv
// Single-port-write, registered-read memory that holds the free codeword of each slot.
`default_nettype none

module ccw_slot_mem #(
   parameter int DEPTH  = 33,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/canonical_codeword_assigner.sv
// Top level of the canonical codeword assigner: sequencer, free flags and result register.
// One code length beat is taken at a time. The sequencer scans the free flags down from
// the entry's length one slot per cycle, reads the found slot's codeword from the slot
// memory in the read state, then refills the deeper slots one per cycle. An entry that
// finds its free slot goes through scanning, reading, filling and loading the output
// register in that order. An entry that finds no free slot goes from scanning straight to
// loading the output register, and an invalid length goes there at once. The last step
// waits while an earlier result is still not taken. The next beat is accepted as soon
// as the sequencer is idle, even while the previous result still waits in the output
// register. Free flags reset at once, so no clearing pass is needed.
`default_nettype none

module canonical_codeword_assigner #(
   parameter int MAX_CODE_LENGTH = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   ccw_req_if.sink   req_ch,
   ccw_rsp_if.source rsp_ch
);

   localparam int SLOTS  = MAX_CODE_LENGTH + 1;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int K_W    = SLOT_W + 1;

   logic [2:0]                 state_ff, state_in;
   logic [SLOTS-1:0]           free_ff, free_in;
   logic [SLOT_W-1:0]          d_ff, d_in;
   logic [K_W-1:0]             k_ff, k_in;
   logic [SLOT_W-1:0]          len_ff, len_in;
   logic                       last_ff, last_in;
   logic                       over_ff, over_in;
   logic [ccw_pkg::CW_W-1:0]   cw_ff, cw_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ccw_pkg::CW_W-1:0]   rsp_cw_ff, rsp_cw_in;
   logic                       rsp_over_ff, rsp_over_in;
   logic                       rsp_incomp_ff, rsp_incomp_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       mem_wr_en;
   logic [SLOT_W-1:0]          mem_wr_addr;
   logic [ccw_pkg::CW_W-1:0]   mem_wr_data;
   logic [ccw_pkg::CW_W-1:0]   mem_rd_data;

   logic                       req_fire;
   logic                       len_ok;
   logic                       rsp_free;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign len_ok   = (req_ch.code_length != '0) &&
                     (req_ch.code_length <= ccw_pkg::LEN_W'(MAX_CODE_LENGTH));
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == ccw_pkg::ST_IDLE);

   // Slot memory holds the codeword of every free slot above slot zero.
   ccw_slot_mem #(
      .DEPTH  (SLOTS),
      .ADDR_W (SLOT_W),
      .DATA_W (ccw_pkg::CW_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (d_ff),
      .rd_data (mem_rd_data)
   );

   // Sequencer: scan down for a free slot, fetch it, refill the deeper slots.
   always_comb begin
      state_in      = state_ff;
      free_in       = free_ff;
      d_in          = d_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      last_in       = last_ff;
      over_in       = over_ff;
      cw_in         = cw_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_cw_in     = rsp_cw_ff;
      rsp_over_in   = rsp_over_ff;
      rsp_incomp_in = rsp_incomp_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = k_ff[SLOT_W-1:0];
      mem_wr_data   = cw_ff | (ccw_pkg::CW_W'(1) << (k_ff - K_W'(1)));

      case (state_ff)
         ccw_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.first_entry) begin
                  free_in = SLOTS'(1);
               end
               len_in  = req_ch.code_length[SLOT_W-1:0];
               d_in    = req_ch.code_length[SLOT_W-1:0];
               last_in = req_ch.last_entry;
               cw_in   = '0;
               over_in = !len_ok;
               state_in = len_ok ? ccw_pkg::ST_SCAN : ccw_pkg::ST_DONE;
            end
         end
         ccw_pkg::ST_SCAN: begin
            if (free_ff[d_ff]) begin
               free_in[d_ff] = 1'b0;
               state_in      = ccw_pkg::ST_READ;
            end else if (d_ff == '0) begin
               over_in  = 1'b1;
               state_in = ccw_pkg::ST_DONE;
            end else begin
               d_in = d_ff - SLOT_W'(1);
            end
         end
         ccw_pkg::ST_READ: begin
            // Slot zero holds only a marker; its codeword is empty.
            cw_in    = (d_ff == '0) ? '0 : mem_rd_data;
            k_in     = K_W'(d_ff) + K_W'(1);
            state_in = ccw_pkg::ST_FILL;
         end
         ccw_pkg::ST_FILL: begin
            if (k_ff <= K_W'(len_ff)) begin
               mem_wr_en                   = 1'b1;
               free_in[k_ff[SLOT_W-1:0]]   = 1'b1;
               k_in                        = k_ff + K_W'(1);
            end else begin
               state_in = ccw_pkg::ST_DONE;
            end
         end
         ccw_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cw_in     = cw_ff;
               rsp_over_in   = over_ff;
               rsp_incomp_in = last_ff && (free_ff != '0);
               rsp_last_in   = last_ff;
               state_in      = ccw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ccw_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccw_pkg::ST_IDLE;
         free_ff      <= SLOTS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      d_ff          <= d_in;
      k_ff          <= k_in;
      len_ff        <= len_in;
      last_ff       <= last_in;
      over_ff       <= over_in;
      cw_ff         <= cw_in;
      rsp_cw_ff     <= rsp_cw_in;
      rsp_over_ff   <= rsp_over_in;
      rsp_incomp_ff <= rsp_incomp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.codeword   = rsp_cw_ff;
   assign rsp_ch.overfull   = rsp_over_ff;
   assign rsp_ch.incomplete = rsp_incomp_ff;
   assign rsp_ch.last_out   = rsp_last_ff;

endmodule

`default_nettype wire

// File: design/ccw_checker.sv
// Port-level checker for the canonical codeword assigner, bound to the top level.
`default_nettype none

module ccw_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [ccw_pkg::CW_W-1:0] rsp_codeword,
   input wire logic                     rsp_overfull,
   input wire logic                     rsp_incomplete,
   input wire logic                     rsp_last_out
);

   // A result beat stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // An accepted length keeps the sequencer busy for the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted again right after a beat");

   // An overfull entry carries an empty codeword.
   a_over_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overfull |-> rsp_codeword == '0)
      else $error("overfull result with a nonzero codeword");

   // Incompleteness is reported on the last entry only.
   a_incomp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_incomplete |-> rsp_last_out)
      else $error("incomplete flag on an entry that is not the last");

endmodule

bind canonical_codeword_assigner ccw_checker u_ccw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_codeword   (rsp_ch.codeword),
   .rsp_overfull   (rsp_ch.overfull),
   .rsp_incomplete (rsp_ch.incomplete),
   .rsp_last_out   (rsp_ch.last_out)
);

`default_nettype wire
